FILE: hw/rtl/cpa_pkg.sv
package cpa_pkg;

  localparam int WORD_W             = 32;
  localparam int BIT_W              = $clog2(WORD_W);
  localparam int PAGE_COUNT_W       = 11;
  localparam int ADDR_W             = 32;

  localparam int PAGE_TOTAL_DEF     = 1024;
  localparam int RESERVED_PAGES_DEF = 8;
  localparam int PAGE_SHIFT_DEF     = 12;

  localparam logic KIND_ALLOC = 1'b0;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
  } search_res_t;

endpackage

FILE: hw/rtl/cpa_map_ram.sv
module cpa_map_ram #(
  parameter int WORDS   = 32,
  parameter int WADDR_W = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [WADDR_W-1:0]         waddr_i,
  input  logic [cpa_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [WADDR_W-1:0]         raddr_i,
  output logic [cpa_pkg::WORD_W-1:0] rdata_o
);
  import cpa_pkg::*;

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/cpa_word_search.sv
module cpa_word_search #(
  parameter int RUN_W = 11
) (
  input  logic [cpa_pkg::WORD_W-1:0]       used_i,
  input  logic [RUN_W-1:0]                 run_i,
  input  logic [cpa_pkg::PAGE_COUNT_W-1:0] count_i,
  output cpa_pkg::search_res_t             res_o,
  output logic [RUN_W-1:0]                 run_o
);
  import cpa_pkg::*;

  localparam int CW = (RUN_W > PAGE_COUNT_W ? RUN_W : PAGE_COUNT_W) + 1;

  logic [WORD_W-1:0] thermo;
  logic [WORD_W-1:0] hit;
  logic [BIT_W-1:0]  hi_used;

  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      thermo[k] = (CW'(count_i) > CW'(k));
    end
  end

  // A bit is a hit when the window of the requested length ending there is free,
  // and the free run carried in from earlier words makes up any shortfall.
  always_comb begin
    logic [WORD_W-1:0] win;
    win = '0;
    for (int i = 0; i < WORD_W; i++) begin
      win = '0;
      for (int j = 0; j <= i; j++) begin
        win[j] = thermo[i-j];
      end
      hit[i] = ~|(used_i & win) && ((CW'(run_i) + CW'(i + 1)) >= CW'(count_i));
    end
  end

  always_comb begin
    res_o.hit     = |hit;
    res_o.bit_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        res_o.bit_idx = BIT_W'(i);
      end
    end
  end

  always_comb begin
    hi_used = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (used_i[i]) begin
        hi_used = BIT_W'(i);
      end
    end
    if (used_i == '0) begin
      run_o = run_i + RUN_W'(WORD_W);
    end else begin
      run_o = RUN_W'(BIT_W'(WORD_W - 1) - hi_used);
    end
  end

endmodule

FILE: hw/rtl/contiguous_page_allocator_unit.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  kind_i, page_count_i, free_address_i
// out       output     out_valid_o / out_stall_i ok_o, block_address_o
// cfg       input      cfg_we_i                 cfg_wdata_i (base address)
//
// The page map is held in words of 32 pages in a single-port-read RAM.
// After reset a clearing pass of one word per cycle loads it.
// A free reads the page's word and clears its bit if set, or goes straight to the
// response when the page lies outside the pool. An allocate scans the words in turn
// and on success marks each word of the run; a zero or oversized count is refused.
// One item is in work at a time; a finished result waits in the output register.
module contiguous_page_allocator_unit #(
  parameter int PAGE_TOTAL     = cpa_pkg::PAGE_TOTAL_DEF,
  parameter int RESERVED_PAGES = cpa_pkg::RESERVED_PAGES_DEF,
  parameter int PAGE_SHIFT     = cpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpa_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             kind_i,
  input  logic [cpa_pkg::PAGE_COUNT_W-1:0] page_count_i,
  input  logic [cpa_pkg::ADDR_W-1:0]       free_address_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [cpa_pkg::ADDR_W-1:0]       block_address_o
);
  import cpa_pkg::*;

  localparam int WORDS   = (PAGE_TOTAL + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PIX_W   = WADDR_W + BIT_W;
  localparam int RUN_W   = $clog2(PAGE_TOTAL + 1);
  localparam int SUM_W   = (PIX_W > PAGE_COUNT_W ? PIX_W : PAGE_COUNT_W) + 1;

  typedef enum logic [6:0] {
    ST_INIT    = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_SCAN    = 7'b0000100,
    ST_MARK_RD = 7'b0001000,
    ST_MARK_WR = 7'b0010000,
    ST_FREE    = 7'b0100000,
    ST_RESP    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]       base_q, base_d;
  logic [WADDR_W-1:0]      clr_q, clr_d;
  logic                    out_valid_q, out_valid_d;

  logic [PAGE_COUNT_W-1:0] n_q, n_d;
  logic [WADDR_W-1:0]      w_q, w_d;
  logic [RUN_W-1:0]        run_q, run_d;
  logic [PIX_W-1:0]        start_q, start_d;
  logic [PIX_W-1:0]        end_q, end_d;
  logic [PIX_W-1:0]        fidx_q, fidx_d;
  logic                    res_ok_q, res_ok_d;
  logic [ADDR_W-1:0]       res_addr_q, res_addr_d;
  logic                    out_ok_q, out_ok_d;
  logic [ADDR_W-1:0]       out_addr_q, out_addr_d;

  logic                    ram_we, ram_re;
  logic [WADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]       ram_wdata, ram_rdata;

  search_res_t             srch;
  logic [RUN_W-1:0]        srch_run;

  logic [ADDR_W-1:0]       free_off;
  logic [ADDR_W-1:0]       free_page;
  logic                    free_in_range;
  logic [SUM_W-1:0]        hit_start;
  logic [WORD_W-1:0]       init_word;
  logic [WORD_W-1:0]       all_ones;
  logic [WORD_W-1:0]       lo_mask, hi_mask;
  logic                    in_acc, out_load;

  cpa_map_ram #(
    .WORDS   (WORDS),
    .WADDR_W (WADDR_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cpa_word_search #(
    .RUN_W (RUN_W)
  ) u_word_search (
    .used_i  (ram_rdata),
    .run_i   (run_q),
    .count_i (n_q),
    .res_o   (srch),
    .run_o   (srch_run)
  );

  assign all_ones      = '1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_load      = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  assign free_off      = free_address_i - base_q;
  assign free_page     = free_off >> PAGE_SHIFT;
  assign free_in_range = (free_page < ADDR_W'(PAGE_TOTAL));

  assign hit_start = SUM_W'({w_q, srch.bit_idx}) + SUM_W'(1) - SUM_W'(n_q);

  assign lo_mask = (w_q == start_q[PIX_W-1:BIT_W]) ?
                   (all_ones << start_q[BIT_W-1:0]) : all_ones;
  assign hi_mask = (w_q == end_q[PIX_W-1:BIT_W]) ?
                   (all_ones >> (BIT_W'(WORD_W - 1) - end_q[BIT_W-1:0])) : all_ones;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      init_word[b] = (32'({clr_q, BIT_W'(b)}) < 32'(RESERVED_PAGES)) ||
                     (32'({clr_q, BIT_W'(b)}) >= 32'(PAGE_TOTAL));
    end
  end

  always_comb begin
    state_d     = state_q;
    base_d      = cfg_we_i ? cfg_wdata_i : base_q;
    clr_d       = clr_q;
    n_d         = n_q;
    w_d         = w_q;
    run_d       = run_q;
    start_d     = start_q;
    end_d       = end_q;
    fidx_d      = fidx_q;
    res_ok_d    = res_ok_q;
    res_addr_d  = res_addr_q;
    ram_we      = 1'b0;
    ram_waddr   = w_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = w_q;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = init_word;
        clr_d     = clr_q + WADDR_W'(1);
        if (clr_q == WADDR_W'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          n_d        = page_count_i;
          if (kind_i == KIND_ALLOC) begin
            if ((page_count_i == '0) ||
                (32'(page_count_i) > 32'(PAGE_TOTAL))) begin
              state_d = ST_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              w_d       = '0;
              run_d     = '0;
              state_d   = ST_SCAN;
            end
          end else begin
            fidx_d = free_page[PIX_W-1:0];
            if (free_in_range) begin
              ram_re    = 1'b1;
              ram_raddr = free_page[PIX_W-1:BIT_W];
              state_d   = ST_FREE;
            end else begin
              state_d = ST_RESP;
            end
          end
        end
      end
      ST_SCAN: begin
        if (srch.hit) begin
          start_d = hit_start[PIX_W-1:0];
          state_d = ST_MARK_RD;
        end else if (w_q == WADDR_W'(WORDS - 1)) begin
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = w_q + WADDR_W'(1);
          w_d       = w_q + WADDR_W'(1);
          run_d     = srch_run;
        end
      end
      ST_MARK_RD: begin
        end_d      = PIX_W'(SUM_W'(start_q) + SUM_W'(n_q) - SUM_W'(1));
        res_ok_d   = 1'b1;
        res_addr_d = base_q + (ADDR_W'(start_q) << PAGE_SHIFT);
        ram_re     = 1'b1;
        ram_raddr  = start_q[PIX_W-1:BIT_W];
        w_d        = start_q[PIX_W-1:BIT_W];
        state_d    = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = w_q;
        ram_wdata = ram_rdata | (lo_mask & hi_mask);
        if (w_q == end_q[PIX_W-1:BIT_W]) begin
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = w_q + WADDR_W'(1);
          w_d       = w_q + WADDR_W'(1);
        end
      end
      ST_FREE: begin
        if (ram_rdata[fidx_q[BIT_W-1:0]]) begin
          ram_we    = 1'b1;
          ram_waddr = fidx_q[PIX_W-1:BIT_W];
          ram_wdata = ram_rdata & ~(WORD_W'(1) << fidx_q[BIT_W-1:0]);
          res_ok_d  = 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_ok_d    = out_ok_q;
    out_addr_d  = out_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_ok_d    = res_ok_q;
      out_addr_d  = res_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      base_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    w_q        <= w_d;
    run_q      <= run_d;
    start_q    <= start_d;
    end_q      <= end_d;
    fidx_q     <= fidx_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    out_ok_q   <= out_ok_d;
    out_addr_q <= out_addr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_ok_q;
  assign block_address_o = out_addr_q;

endmodule
